### hw/rtl/ptw_pkg.sv
// Shared types and constants of the two-level page table walker.
package ptw_pkg;

    localparam int PROC_W    = 4;
    localparam int VPAGE_W   = 6;
    localparam int FRAME_W   = 8;
    localparam int USES_W    = 8;
    localparam int FAULTS_W  = 16;
    localparam int USED_W    = 9;
    localparam int PCOUNT_W  = 5;
    localparam int STATUS_W  = 2;

    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd1;

    localparam logic [STATUS_W-1:0] STATUS_DONE        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FRAME    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PROCESS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK1,
        ST_READ2,
        ST_WALK2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic walk1;
        logic sel2;
        logic walk2;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic in_bad;
        logic hit;
        logic free;
        logic out_free;
    } sts_t;

endpackage

### hw/rtl/two_level_page_table_walker.sv
// Top level of the two-level page table walker with demand paging.
//
//   channel   signals                          direction  payload
//   input     in_valid / in_ready              in         process, virtual_page
//   result    out_valid / out_ready            out        status .. frames_used
//   config    cfg_valid / cfg_ready            in         process_count
//
// A reference to a configured process makes two dependent reads of the table memory on its way
// to the result register, each followed by write-back and allocation; the walk ends after the
// first if it misses and no frame is free. An unconfigured process goes straight to the result.
// Reset clears the per-row valid flags, so no clearing pass runs; the block is ready at once.
// A new item is accepted while the previous result waits; the walk stalls in its last
// cycle only if that result has still not been taken.
module two_level_page_table_walker
#(
    parameter int FRAMES     = 256,
    parameter int L1_ENTRIES = 8,
    parameter int L2_ENTRIES = 8,
    parameter int PROCESSES  = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ptw_pkg::PCOUNT_W-1:0]     process_count,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ptw_pkg::PROC_W-1:0]       process,
    input  logic [ptw_pkg::VPAGE_W-1:0]      virtual_page,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ptw_pkg::STATUS_W-1:0]     status,
    output logic                             table_fault,
    output logic [ptw_pkg::FRAME_W-1:0]      table_frame,
    output logic                             page_fault,
    output logic [ptw_pkg::FRAME_W-1:0]      mapped_frame,
    output logic [ptw_pkg::USES_W-1:0]       use_count,
    output logic [ptw_pkg::FAULTS_W-1:0]     process_faults,
    output logic [ptw_pkg::USED_W-1:0]       frames_used
);

    ptw_pkg::cmd_t cmd;
    ptw_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    ptw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptw_dp
    #(
        .FRAMES     (FRAMES),
        .L1_ENTRIES (L1_ENTRIES),
        .L2_ENTRIES (L2_ENTRIES),
        .PROCESSES  (PROCESSES)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_valid),
        .process_count  (process_count),
        .process        (process),
        .virtual_page   (virtual_page),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .table_fault    (table_fault),
        .table_frame    (table_frame),
        .page_fault     (page_fault),
        .mapped_frame   (mapped_frame),
        .use_count      (use_count),
        .process_faults (process_faults),
        .frames_used    (frames_used)
    );

endmodule

### hw/rtl/ptw_ctrl.sv
// Controller state machine that sequences one page walk at a time.
module ptw_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ptw_pkg::sts_t sts,
    output ptw_pkg::cmd_t cmd
);

    ptw_pkg::state_t state_reg;
    ptw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.in_bad ? ptw_pkg::ST_DONE : ptw_pkg::ST_WALK1;
                end
            end
            ptw_pkg::ST_WALK1:
            begin
                state_next = (!sts.hit && !sts.free) ? ptw_pkg::ST_DONE
                                                     : ptw_pkg::ST_READ2;
            end
            ptw_pkg::ST_READ2:
            begin
                state_next = ptw_pkg::ST_WALK2;
            end
            ptw_pkg::ST_WALK2:
            begin
                state_next = ptw_pkg::ST_DONE;
            end
            ptw_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ptw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ptw_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ptw_pkg::ST_WALK1:
            begin
                cmd.walk1 = 1'b1;
            end
            ptw_pkg::ST_READ2:
            begin
                cmd.sel2 = 1'b1;
            end
            ptw_pkg::ST_WALK2:
            begin
                cmd.sel2  = 1'b1;
                cmd.walk2 = 1'b1;
            end
            ptw_pkg::ST_DONE:
            begin
                cmd.load = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // An unconfigured process goes straight to the result.
    a_bad_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && sts.in_bad |=> state_reg == ptw_pkg::ST_DONE)
        else $error("unconfigured process did not go to the result state");

endmodule

### hw/rtl/ptw_dp.sv
// Datapath of the walker: table memories, frame allocator, fault counts and result register.
module ptw_dp
#(
    parameter int FRAMES     = 256,
    parameter int L1_ENTRIES = 8,
    parameter int L2_ENTRIES = 8,
    parameter int PROCESSES  = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  ptw_pkg::cmd_t                    cmd,
    output ptw_pkg::sts_t                    sts,
    input  logic                             cfg_we,
    input  logic [ptw_pkg::PCOUNT_W-1:0]     process_count,
    input  logic [ptw_pkg::PROC_W-1:0]       process,
    input  logic [ptw_pkg::VPAGE_W-1:0]      virtual_page,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ptw_pkg::STATUS_W-1:0]     status,
    output logic                             table_fault,
    output logic [ptw_pkg::FRAME_W-1:0]      table_frame,
    output logic                             page_fault,
    output logic [ptw_pkg::FRAME_W-1:0]      mapped_frame,
    output logic [ptw_pkg::USES_W-1:0]       use_count,
    output logic [ptw_pkg::FAULTS_W-1:0]     process_faults,
    output logic [ptw_pkg::USED_W-1:0]       frames_used
);

    localparam int SLOTS = (L1_ENTRIES > L2_ENTRIES) ? L1_ENTRIES : L2_ENTRIES;
    localparam int SW    = $clog2(SLOTS);
    localparam int RW    = $clog2(FRAMES);
    localparam int FA_W  = $clog2(FRAMES + 1);
    localparam int NW    = FA_W + 1;
    localparam int PW    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int DEPTH = FRAMES * (2 ** SW);
    localparam int VP_N  = 2 ** ptw_pkg::VPAGE_W;
    localparam int EW    = ptw_pkg::FRAME_W + ptw_pkg::USES_W;

    localparam logic [ptw_pkg::PCOUNT_W-1:0] PROC_LIMIT = ptw_pkg::PCOUNT_W'(PROCESSES);
    localparam logic [NW-1:0]                FRAME_LIM  = NW'(FRAMES);
    localparam logic [ptw_pkg::FAULTS_W-1:0] FAULT_MAX  = '1;

    function automatic logic [VP_N*SW-1:0] l1_table();
        logic [VP_N*SW-1:0] t;
        t = '0;
        for (int i = 0; i < VP_N; i++)
        begin
            t[i*SW +: SW] = SW'((i / L2_ENTRIES) % L1_ENTRIES);
        end
        return t;
    endfunction

    function automatic logic [VP_N*SW-1:0] l2_table();
        logic [VP_N*SW-1:0] t;
        t = '0;
        for (int i = 0; i < VP_N; i++)
        begin
            t[i*SW +: SW] = SW'(i % L2_ENTRIES);
        end
        return t;
    endfunction

    localparam logic [VP_N*SW-1:0] L1_TAB = l1_table();
    localparam logic [VP_N*SW-1:0] L2_TAB = l2_table();

    logic [EW-1:0]     ent_mem [DEPTH];
    logic [SLOTS-1:0]  vld_mem [FRAMES];

    logic [ptw_pkg::PCOUNT_W-1:0] pc_reg;
    logic [FA_W-1:0]              fa_reg;
    logic [ptw_pkg::FAULTS_W-1:0] fault_reg [PROCESSES];
    logic [FRAMES-1:0]            row_ok_reg;
    logic [FRAMES-1:0]            row_ok_next;
    logic                         out_valid_reg;

    logic [ptw_pkg::PROC_W-1:0]   p_reg;
    logic [SW-1:0]                l1_reg;
    logic [SW-1:0]                l2_reg;
    logic [ptw_pkg::STATUS_W-1:0] status_reg;
    logic                         tfault_reg;
    logic [ptw_pkg::FRAME_W-1:0]  tframe_reg;
    logic                         pfault_reg;
    logic [ptw_pkg::FRAME_W-1:0]  pframe_reg;
    logic [ptw_pkg::USES_W-1:0]   uses_reg;

    logic [EW-1:0]                ent_rd_reg;
    logic [SLOTS-1:0]             vld_rd_reg;
    logic                         rowok_rd_reg;

    logic [ptw_pkg::STATUS_W-1:0] status_out_reg;
    logic                         tfault_out_reg;
    logic [ptw_pkg::FRAME_W-1:0]  tframe_out_reg;
    logic                         pfault_out_reg;
    logic [ptw_pkg::FRAME_W-1:0]  pframe_out_reg;
    logic [ptw_pkg::USES_W-1:0]   uses_out_reg;
    logic [ptw_pkg::FAULTS_W-1:0] faults_out_reg;
    logic [ptw_pkg::USED_W-1:0]   used_out_reg;

    logic [RW-1:0]                in_row;
    logic [SW-1:0]                in_l1;
    logic [SW-1:0]                in_l2;
    logic                         in_bad;
    logic [RW-1:0]                p_row;
    logic [RW-1:0]                tf_row;
    logic [RW-1:0]                rd_row;
    logic [SW-1:0]                rd_slot;
    logic [RW-1:0]                wr_row;
    logic [SW-1:0]                wr_slot;
    logic [SLOTS-1:0]             slot_bit;
    logic [SLOTS-1:0]             vld_wdata;
    logic [EW-1:0]                ent_wdata;
    logic                         ent_we;
    logic                         hit;
    logic [NW-1:0]                next_frame;
    logic                         free;
    logic [RW-1:0]                new_frame;
    logic                         walking;
    logic                         alloc;
    logic                         fail;
    logic [PW-1:0]                p_idx;
    logic [ptw_pkg::FRAME_W-1:0]  rd_frame;
    logic [ptw_pkg::USES_W-1:0]   rd_uses;

    always_comb
    begin
        in_row     = RW'(process);
        in_l1      = L1_TAB[virtual_page*SW +: SW];
        in_l2      = L2_TAB[virtual_page*SW +: SW];
        in_bad     = ({1'b0, process} >= pc_reg) || ({1'b0, process} >= PROC_LIMIT);
        p_row      = RW'(p_reg);
        tf_row     = tframe_reg[RW-1:0];
        rd_row     = cmd.sel2 ? tf_row : in_row;
        rd_slot    = cmd.sel2 ? l2_reg : in_l1;
        wr_row     = cmd.sel2 ? tf_row : p_row;
        wr_slot    = cmd.sel2 ? l2_reg : l1_reg;
        slot_bit   = '0;
        slot_bit[wr_slot] = 1'b1;
        hit        = rowok_rd_reg & vld_rd_reg[wr_slot];
        next_frame = NW'(pc_reg) + NW'(fa_reg);
        free       = next_frame < FRAME_LIM;
        new_frame  = next_frame[RW-1:0];
        walking    = cmd.walk1 | cmd.walk2;
        alloc      = walking & ~hit & free;
        fail       = walking & ~hit & ~free;
        vld_wdata  = (rowok_rd_reg ? vld_rd_reg : '0) | slot_bit;
        rd_frame   = ent_rd_reg[EW-1 -: ptw_pkg::FRAME_W];
        rd_uses    = ent_rd_reg[ptw_pkg::USES_W-1:0];
        ent_we     = alloc | (cmd.walk2 & hit);
        if (alloc)
        begin
            ent_wdata = {ptw_pkg::FRAME_W'(new_frame),
                         cmd.walk2 ? ptw_pkg::USES_W'(1) : rd_uses};
        end
        else
        begin
            ent_wdata = {rd_frame, rd_uses + ptw_pkg::USES_W'(1)};
        end
        p_idx      = p_reg[PW-1:0];
    end

    always_comb
    begin
        row_ok_next = row_ok_reg;
        if (alloc)
        begin
            row_ok_next[wr_row] = 1'b1;
        end
        // A new second-level table starts with every entry invalid.
        if (alloc && cmd.walk1)
        begin
            row_ok_next[new_frame] = 1'b0;
        end
    end

    always_comb
    begin
        sts.in_bad   = in_bad;
        sts.hit      = hit;
        sts.free     = free;
        sts.out_free = ~out_valid_reg | out_ready;
    end

    // Table memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[{wr_row, wr_slot}] <= ent_wdata;
        end
        if (alloc)
        begin
            vld_mem[wr_row] <= vld_wdata;
        end
        ent_rd_reg   <= ent_mem[{rd_row, rd_slot}];
        vld_rd_reg   <= vld_mem[rd_row];
        rowok_rd_reg <= row_ok_reg[rd_row];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ptw_pkg::PCOUNT_RESET;
            fa_reg        <= '0;
            row_ok_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PROCESSES; i++)
            begin
                fault_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                pc_reg <= process_count;
            end
            row_ok_reg <= row_ok_next;
            if (alloc)
            begin
                fa_reg <= fa_reg + FA_W'(1);
                if (fault_reg[p_idx] != FAULT_MAX)
                begin
                    fault_reg[p_idx] <= fault_reg[p_idx] + ptw_pkg::FAULTS_W'(1);
                end
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            p_reg      <= process;
            l1_reg     <= in_l1;
            l2_reg     <= in_l2;
            status_reg <= in_bad ? ptw_pkg::STATUS_BAD_PROCESS : ptw_pkg::STATUS_DONE;
            tfault_reg <= 1'b0;
            tframe_reg <= '0;
            pfault_reg <= 1'b0;
            pframe_reg <= '0;
            uses_reg   <= '0;
        end
        if (fail)
        begin
            status_reg <= ptw_pkg::STATUS_NO_FRAME;
        end
        if (cmd.walk1 && hit)
        begin
            tframe_reg <= rd_frame;
        end
        if (cmd.walk1 && alloc)
        begin
            tfault_reg <= 1'b1;
            tframe_reg <= ptw_pkg::FRAME_W'(new_frame);
        end
        if (cmd.walk2 && hit)
        begin
            pframe_reg <= rd_frame;
            uses_reg   <= rd_uses + ptw_pkg::USES_W'(1);
        end
        if (cmd.walk2 && alloc)
        begin
            pfault_reg <= 1'b1;
            pframe_reg <= ptw_pkg::FRAME_W'(new_frame);
            uses_reg   <= ptw_pkg::USES_W'(1);
        end
        if (cmd.load)
        begin
            status_out_reg <= status_reg;
            tfault_out_reg <= tfault_reg;
            tframe_out_reg <= tframe_reg;
            pfault_out_reg <= pfault_reg;
            pframe_out_reg <= pframe_reg;
            uses_out_reg   <= uses_reg;
            faults_out_reg <= (status_reg == ptw_pkg::STATUS_BAD_PROCESS) ? '0
                                                                         : fault_reg[p_idx];
            used_out_reg   <= ptw_pkg::USED_W'(next_frame);
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_out_reg;
    assign table_fault    = tfault_out_reg;
    assign table_frame    = tframe_out_reg;
    assign page_fault     = pfault_out_reg;
    assign mapped_frame   = pframe_out_reg;
    assign use_count      = uses_out_reg;
    assign process_faults = faults_out_reg;
    assign frames_used    = used_out_reg;

    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |=> fa_reg == $past(fa_reg) + FA_W'(1))
        else $error("frame allocator did not advance by one");

    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        FA_W'(fa_reg) <= FA_W'(FRAMES))
        else $error("more frames handed out than exist");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid_reg)
        else $error("loaded result not offered");

    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_out_reg == ptw_pkg::STATUS_BAD_PROCESS
        |-> faults_out_reg == '0 && !tfault_out_reg && !pfault_out_reg)
        else $error("unconfigured process result carries walk data");

endmodule
